>>> rtl/sle_pkg.sv
package sle_pkg;

  localparam logic [2:0] MODE_CLEAR  = 3'd0;
  localparam logic [2:0] MODE_INSERT = 3'd1;
  localparam logic [2:0] MODE_DELETE = 3'd2;
  localparam logic [2:0] MODE_GET    = 3'd3;
  localparam logic [2:0] MODE_LOCATE = 3'd4;
  localparam logic [2:0] MODE_PRIOR  = 3'd5;
  localparam logic [2:0] MODE_NEXT   = 3'd6;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BADPOS   = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  // read port use: shift up, shift down, scan, read at request position
  typedef enum logic [1:0] {
    RD_INS,
    RD_DEL,
    RD_SRCH,
    RD_POS
  } rd_kind_t;

  typedef enum logic [1:0] {
    IDX_CNT,
    IDX_POS,
    IDX_ZERO
  } idx_src_t;

  typedef struct packed {
    logic       capture;
    logic       clear_cnt;
    logic       inc_cnt;
    logic       dec_cnt;
    logic       rd_en;
    rd_kind_t   rd_kind;
    logic       idx_load;
    idx_src_t   idx_src;
    logic       idx_inc;
    logic       idx_dec;
    logic       wr_put;
    logic       fval_rd;
    logic       fval_prev;
    logic       latch_match;
    logic       fpos_load;
    logic       finish;
    logic [1:0] status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       ins_ok;
    logic       acc_ok;
    logic       idx_ge_pos;
    logic       idx_lt_cnt;
    logic       cmp_pend;
    logic       hit;
    logic       match_first;
    logic       match_has_next;
    logic       out_free;
  } stat_t;

endpackage

>>> rtl/sle_datapath.sv
module sle_datapath
  import sle_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [2:0]         in_mode,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_found_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_list_length,
  output logic               out_is_empty
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > 8) ? CW : 8) + 1;

  logic [31:0]   entry_store_r [CAPACITY];
  logic [2:0]    mode_r;
  logic [7:0]    pos_r;
  logic [31:0]   val_r;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] cidx_r;
  logic [CW-1:0] match_r;
  logic [31:0]   rdata_r;
  logic [31:0]   prev_r;
  logic [31:0]   fval_r, fval_nxt;
  logic [7:0]    fpos_r, fpos_nxt;
  logic          wr_pend_r;
  logic [IW-1:0] wr_addr_r;
  logic          cmp_pend_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic [31:0]   out_fval_r;
  logic [7:0]    out_fpos_r;
  logic [7:0]    out_len_r;
  logic          out_empty_r;

  logic [XW-1:0] pos_x, cnt_x, idx_x, pos_m1, idx_m1, match_p1, len_x;
  logic [IW-1:0] rd_addr, pend_addr;
  logic          hit;

  assign pos_x    = XW'(pos_r);
  assign cnt_x    = XW'(count_r);
  assign idx_x    = XW'(idx_r);
  assign pos_m1   = pos_x - XW'(1);
  assign idx_m1   = idx_x - XW'(1);
  assign match_p1 = XW'(match_r) + XW'(1);
  assign hit      = cmp_pend_r && (rdata_r == val_r);

  always_comb begin
    rd_addr   = idx_r[IW-1:0];
    pend_addr = idx_r[IW-1:0];
    case (cmd.rd_kind)
      RD_INS: begin
        rd_addr   = idx_m1[IW-1:0];
        pend_addr = idx_r[IW-1:0];
      end
      RD_DEL: begin
        rd_addr   = idx_r[IW-1:0];
        pend_addr = idx_m1[IW-1:0];
      end
      RD_SRCH: rd_addr = idx_r[IW-1:0];
      RD_POS:  rd_addr = pos_m1[IW-1:0];
      default: rd_addr = idx_r[IW-1:0];
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear_cnt) begin
      count_nxt = '0;
    end else if (cmd.inc_cnt) begin
      count_nxt = count_r + CW'(1);
    end else if (cmd.dec_cnt) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    fval_nxt = fval_r;
    fpos_nxt = fpos_r;
    if (cmd.capture) begin
      fval_nxt = '0;
      fpos_nxt = '0;
    end else if (cmd.fval_rd) begin
      fval_nxt = rdata_r;
    end else if (cmd.fval_prev) begin
      fval_nxt = prev_r;
    end else if (cmd.fpos_load) begin
      fpos_nxt = match_p1[7:0];
    end
  end

  assign len_x = XW'(count_nxt);

  assign stat.mode           = mode_r;
  assign stat.full           = cnt_x >= XW'(CAPACITY);
  assign stat.ins_ok         = (pos_x != '0) && (pos_x <= cnt_x + XW'(1));
  assign stat.acc_ok         = (pos_x != '0) && (pos_x <= cnt_x);
  assign stat.idx_ge_pos     = idx_x >= pos_x;
  assign stat.idx_lt_cnt     = idx_r < count_r;
  assign stat.cmp_pend       = cmp_pend_r;
  assign stat.hit            = hit;
  assign stat.match_first    = match_r == '0;
  assign stat.match_has_next = match_p1 < cnt_x;
  assign stat.out_free       = !out_valid_r || out_ready;

  // entry store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.wr_put) begin
      entry_store_r[pos_m1[IW-1:0]] <= val_r;
    end else if (wr_pend_r) begin
      entry_store_r[wr_addr_r] <= rdata_r;
    end
    if (cmd.rd_en) begin
      rdata_r <= entry_store_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      pos_r  <= in_position;
      val_r  <= in_item_value;
    end
    if (cmd.idx_load) begin
      case (cmd.idx_src)
        IDX_CNT:  idx_r <= count_r;
        IDX_POS:  idx_r <= pos_x[CW-1:0];
        IDX_ZERO: idx_r <= '0;
        default:  idx_r <= '0;
      endcase
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + CW'(1);
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - CW'(1);
    end
    wr_addr_r <= pend_addr;
    if (cmd.rd_en && (cmd.rd_kind == RD_SRCH)) begin
      cidx_r <= idx_r;
    end
    if (cmd.latch_match) begin
      match_r <= cidx_r;
    end
    if (cmp_pend_r && !hit) begin
      prev_r <= rdata_r;
    end
    fval_r <= fval_nxt;
    fpos_r <= fpos_nxt;
    if (cmd.finish) begin
      out_status_r <= cmd.status;
      out_fval_r   <= fval_nxt;
      out_fpos_r   <= fpos_nxt;
      out_len_r    <= len_x[7:0];
      out_empty_r  <= count_nxt == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      cmp_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      wr_pend_r   <= cmd.rd_en && ((cmd.rd_kind == RD_INS) || (cmd.rd_kind == RD_DEL));
      cmp_pend_r  <= cmd.rd_en && (cmd.rd_kind == RD_SRCH);
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_found_value    = out_fval_r;
  assign out_found_position = out_fpos_r;
  assign out_list_length    = out_len_r;
  assign out_is_empty       = out_empty_r;

endmodule

>>> rtl/sle_ctrl.sv
module sle_ctrl
  import sle_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_INS_SHIFT,
    S_INS_PUT,
    S_DEL_GRAB,
    S_DEL_SHIFT,
    S_GET_WAIT,
    S_SRCH,
    S_SRCH_HIT
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE) && stat.out_free;

  always_comb begin
    cmd         = '0;
    cmd.rd_kind = RD_SRCH;
    cmd.idx_src = IDX_ZERO;
    cmd.status  = ST_OK;
    state_nxt   = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_IDLE;
        case (stat.mode)
          MODE_CLEAR: begin
            cmd.clear_cnt = 1'b1;
            cmd.finish    = 1'b1;
          end
          MODE_INSERT: begin
            if (stat.full) begin
              cmd.finish = 1'b1;
              cmd.status = ST_FULL;
            end else if (!stat.ins_ok) begin
              cmd.finish = 1'b1;
              cmd.status = ST_BADPOS;
            end else begin
              cmd.idx_load = 1'b1;
              cmd.idx_src  = IDX_CNT;
              state_nxt    = S_INS_SHIFT;
            end
          end
          MODE_DELETE, MODE_GET: begin
            if (!stat.acc_ok) begin
              cmd.finish = 1'b1;
              cmd.status = ST_BADPOS;
            end else begin
              cmd.rd_en   = 1'b1;
              cmd.rd_kind = RD_POS;
              state_nxt   = (stat.mode == MODE_DELETE) ? S_DEL_GRAB : S_GET_WAIT;
            end
          end
          MODE_LOCATE, MODE_PRIOR, MODE_NEXT: begin
            cmd.idx_load = 1'b1;
            cmd.idx_src  = IDX_ZERO;
            state_nxt    = S_SRCH;
          end
          default: begin
            cmd.finish = 1'b1;
            cmd.status = ST_BADPOS;
          end
        endcase
      end
      S_INS_SHIFT: begin
        if (stat.idx_ge_pos) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_kind = RD_INS;
          cmd.idx_dec = 1'b1;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        cmd.wr_put  = 1'b1;
        cmd.inc_cnt = 1'b1;
        cmd.finish  = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DEL_GRAB: begin
        cmd.fval_rd  = 1'b1;
        cmd.idx_load = 1'b1;
        cmd.idx_src  = IDX_POS;
        state_nxt    = S_DEL_SHIFT;
      end
      S_DEL_SHIFT: begin
        if (stat.idx_lt_cnt) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_kind = RD_DEL;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.dec_cnt = 1'b1;
          cmd.finish  = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_GET_WAIT: begin
        cmd.fval_rd = 1'b1;
        cmd.finish  = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SRCH: begin
        cmd.rd_en   = stat.idx_lt_cnt;
        cmd.rd_kind = RD_SRCH;
        cmd.idx_inc = stat.idx_lt_cnt;
        if (stat.hit) begin
          cmd.latch_match = 1'b1;
          state_nxt       = S_SRCH_HIT;
        end else if (!stat.idx_lt_cnt && !stat.cmp_pend) begin
          cmd.finish = 1'b1;
          cmd.status = ST_NOTFOUND;
          state_nxt  = S_IDLE;
        end
      end
      S_SRCH_HIT: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
        case (stat.mode)
          MODE_LOCATE: cmd.fpos_load = 1'b1;
          MODE_PRIOR: begin
            if (stat.match_first) begin
              cmd.status = ST_NOTFOUND;
            end else begin
              cmd.fval_prev = 1'b1;
            end
          end
          default: begin
            if (stat.match_has_next) begin
              cmd.fval_rd = 1'b1;
            end else begin
              cmd.status = ST_NOTFOUND;
            end
          end
        endcase
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/sequential_list_engine_core.sv
// Ordered list of up to CAPACITY signed 32-bit entries, 1-based positions.
// Input channel in_*: one request (mode, position, item_value) per accept.
// Output channel out_*: exactly one result per request, in request order.
// Insert at p moves the entries from p on up by one, delete at p moves
// those after p down by one; locate / prior / next scan from the first
// entry until a match or the end of the list. Rate is set by the entry
// store, with one read and one write port: shifts and scans move one
// entry per cycle.
// One request is in flight at a time; in_ready is high only while the
// engine is idle and the result register is empty or being drained.
// A result waits in its output register while out_ready is low; the next
// request is taken as soon as that result is accepted.
// Reset empties the list at once; store contents are left undefined and
// are never read before being written.
module sequential_list_engine_core
  import sle_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_mode,
  input  logic [7:0]         in_position,
  input  logic signed [31:0] in_item_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_found_value,
  output logic [7:0]         out_found_position,
  output logic [7:0]         out_list_length,
  output logic               out_is_empty
);

  cmd_t  cmd;
  stat_t stat;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sle_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_mode            (in_mode),
    .in_position        (in_position),
    .in_item_value      (in_item_value),
    .cmd                (cmd),
    .stat               (stat),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_found_value    (out_found_value),
    .out_found_position (out_found_position),
    .out_list_length    (out_list_length),
    .out_is_empty       (out_is_empty)
  );

endmodule

>>> rtl/sle_checker.sv
module sle_checker
  import sle_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         out_status,
  input logic signed [31:0] out_found_value,
  input logic [7:0]         out_found_position,
  input logic [7:0]         out_list_length,
  input logic               out_is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_found_value) && $stable(out_list_length))
    else $error("result changed while stalled");

  a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> out_list_length == 8'(CAPACITY))
    else $error("full status with list not at capacity");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NOTFOUND) |->
      (out_found_value == 32'sd0) && (out_found_position == 8'd0))
    else $error("miss result carries a value or position");

  a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (CAPACITY < 256) |-> out_is_empty == (out_list_length == 8'd0))
    else $error("empty flag disagrees with length");

endmodule

bind sequential_list_engine_core sle_checker #(
  .CAPACITY (CAPACITY)
) u_sle_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_found_value    (out_found_value),
  .out_found_position (out_found_position),
  .out_list_length    (out_list_length),
  .out_is_empty       (out_is_empty)
);
